// ----- sv/cbs_pkg.sv -----
// Shared types and constants of the centered binomial sampler.
package cbs_pkg;

  localparam int unsigned EtaW       = 3;
  localparam int unsigned EtaReset   = 2;
  localparam int unsigned EtaMin     = 1;
  localparam int unsigned EtaMax     = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BufW       = 17;
  localparam int unsigned HeldW      = 5;
  localparam int unsigned ChunkW     = 12;
  localparam int unsigned CountW     = 3;
  localparam int unsigned CoeffW     = 4;
  localparam int unsigned IndexW     = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PolyLengthDefault = 256;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  // Register index of eta on the configuration port.
  localparam logic RegEta = 1'b0;

  // One queued job: the stream bits of all coefficients that one byte completes.
  typedef struct packed {
    logic [ChunkW-1:0] chunk;
    logic [CountW-1:0] count;
  } cbs_job_t;

endpackage

// ----- sv/cbs_front.sv -----
// Front end: appends each byte to the bit buffer and queues the coefficients it completes.
module cbs_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic [cbs_pkg::EtaW-1:0]   eta_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [cbs_pkg::ByteW-1:0]  random_byte_i,
  input  logic                       queue_full_i,
  output logic                       job_push_o,
  output cbs_pkg::cbs_job_t          job_o
);
  import cbs_pkg::*;

  logic [BufW-1:0]   buf_q, buf_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [BufW-1:0]   window;
  logic [HeldW-1:0]  held_plus;
  logic [5:0]        w1, w2, w3, w4, consumed;
  logic [CountW-1:0] n;
  logic              accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    window    = buf_q | ({{(BufW-ByteW){1'b0}}, random_byte_i} << held_q);
    held_plus = held_q + HeldW'(ByteW);
    w1 = {2'b00, eta_i, 1'b0};
    w2 = {1'b0, eta_i, 2'b00};
    w3 = w1 + w2;
    w4 = {eta_i, 3'b000};
    n  = CountW'({1'b0, held_plus} >= w1) + CountW'({1'b0, held_plus} >= w2)
       + CountW'({1'b0, held_plus} >= w3) + CountW'({1'b0, held_plus} >= w4);
    unique case (n)
      3'd1:    consumed = w1;
      3'd2:    consumed = w2;
      3'd3:    consumed = w3;
      3'd4:    consumed = w4;
      default: consumed = '0;
    endcase
    buf_d  = buf_q;
    held_d = held_q;
    if (clear_i) begin
      buf_d  = '0;
      held_d = '0;
    end else if (accept) begin
      buf_d  = window >> consumed;
      held_d = held_plus - consumed[HeldW-1:0];
    end
  end

  assign job_push_o  = accept && (n != '0);
  assign job_o.chunk = window[ChunkW-1:0];
  assign job_o.count = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
    end else begin
      buf_q  <= buf_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- sv/cbs_fifo.sv -----
// Short job queue between the front end and the back end.
module cbs_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cbs_pkg::cbs_job_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cbs_pkg::cbs_job_t head_o
);
  import cbs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cbs_job_t          entry_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- sv/cbs_back.sv -----
// Back end: turns jobs into coefficients with the polynomial index, one per unstalled cycle.
module cbs_back #(
  parameter int unsigned PolyLength = cbs_pkg::PolyLengthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clear_i,
  input  logic [cbs_pkg::EtaW-1:0]          eta_i,
  input  logic                              job_valid_i,
  input  cbs_pkg::cbs_job_t                 job_i,
  output logic                              job_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cbs_pkg::CoeffW-1:0] coefficient_o,
  output logic [cbs_pkg::IndexW-1:0]        coeff_index_o,
  output logic                              poly_end_o,
  output logic                              run_last_o
);
  import cbs_pkg::*;

  localparam int unsigned CntW = $clog2(PolyLength);

  function automatic logic [2:0] popcnt5(input logic [4:0] v);
    logic [2:0] c;
    c = '0;
    for (int i = 0; i < 5; i++) begin
      c = c + 3'(v[i]);
    end
    return c;
  endfunction

  logic [ChunkW-1:0]      chunk_q, chunk_d;
  logic [CountW-1:0]      left_q, left_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [CoeffW-1:0]      coeff_q;
  logic [IndexW-1:0]      index_q;
  logic                   poly_end_q, run_last_q;
  logic                   out_free, emit, load, last;
  logic [4:0]             half_mask, lo_bits, hi_bits;
  logic [2:0]             ones_lo, ones_hi;
  logic [3:0]             width;
  logic [CntW+IndexW-1:0] cnt_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (left_q != '0) && out_free;
  // The next job may load in the cycle that the current one hands over its last coefficient.
  assign load      = job_valid_i && ((left_q == '0) || ((left_q == CountW'(1)) && emit));
  assign job_pop_o = load;

  always_comb begin
    width     = {eta_i, 1'b0};
    half_mask = 5'((6'd1 << eta_i) - 6'd1);
    lo_bits   = chunk_q[4:0] & half_mask;
    hi_bits   = 5'(chunk_q >> eta_i) & half_mask;
    ones_lo   = popcnt5(lo_bits);
    ones_hi   = popcnt5(hi_bits);
    last      = (cnt_q == CntW'(PolyLength - 1));
    cnt_ext   = {{IndexW{1'b0}}, cnt_q};

    chunk_d     = chunk_q;
    left_d      = left_q;
    cnt_d       = cnt_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (emit) begin
      chunk_d     = chunk_q >> width;
      left_d      = left_q - 1'b1;
      cnt_d       = last ? '0 : cnt_q + 1'b1;
      out_valid_d = 1'b1;
    end
    if (load) begin
      chunk_d = job_i.chunk;
      left_d  = job_i.count;
    end
    if (clear_i) begin
      cnt_d  = '0;
      left_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      coeff_q    <= {1'b0, ones_lo} - {1'b0, ones_hi};
      index_q    <= cnt_ext[IndexW-1:0];
      poly_end_q <= last;
      run_last_q <= (left_q == CountW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q     <= '0;
      left_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chunk_q     <= chunk_d;
      left_q      <= left_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coeff_q;
  assign coeff_index_o = index_q;
  assign poly_end_o    = poly_end_q;
  assign run_last_o    = run_last_q;

endmodule

// ----- sv/centered_binomial_sampler.sv -----
// Centered binomial sampler: random bytes in, signed coefficients out, eta set over APB.
// Random bytes form one bit stream, bit 0 first; each coefficient uses 2*eta bits and equals
// the popcount of the first eta bits minus that of the next eta. A byte is taken in every
// cycle while the two-entry job queue has room; the back end hands out one coefficient per
// cycle while the receiver is ready; a byte occupies it once per coefficient it completes
// (always four at eta 1, at most two at larger eta, and none for some bytes at eta 5); the
// output transfer rate of one coefficient per cycle sets the sustained throughput. A byte's
// first coefficient passes the job queue, the chunk register and the output register.
// Writing eta (register 0 at address 0; 0 reads as 1, 6 and 7 as 5) flushes the held
// bits and restarts the polynomial index at zero; write it only while the block is idle.
module centered_binomial_sampler #(
  parameter int unsigned PolyLength = cbs_pkg::PolyLengthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbs_pkg::ApbAddrW-1:0]      paddr,
  input  logic [cbs_pkg::ApbDataW-1:0]      pwdata,
  output logic [cbs_pkg::ApbDataW-1:0]      prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cbs_pkg::ByteW-1:0]         random_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cbs_pkg::CoeffW-1:0] coefficient_o,
  output logic [cbs_pkg::IndexW-1:0]        coeff_index_o,
  output logic                              poly_end_o,
  output logic                              run_last_o
);
  import cbs_pkg::*;

  logic [EtaW-1:0] eta_q, eta_d;
  logic            cfg_write, eta_write;
  logic            queue_full, job_push, job_valid, job_pop;
  cbs_job_t        push_job, head_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign eta_write = cfg_write && (paddr[2] == RegEta);
  assign prdata    = (paddr[2] == RegEta) ? {{(ApbDataW-EtaW){1'b0}}, eta_q} : '0;

  always_comb begin
    eta_d = pwdata[EtaW-1:0];
    if (eta_d < EtaW'(EtaMin)) begin
      eta_d = EtaW'(EtaMin);
    end else if (eta_d > EtaW'(EtaMax)) begin
      eta_d = EtaW'(EtaMax);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q <= EtaW'(EtaReset);
    end else if (eta_write) begin
      eta_q <= eta_d;
    end
  end

  cbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (eta_write),
    .eta_i         (eta_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .random_byte_i (random_byte_i),
    .queue_full_i  (queue_full),
    .job_push_o    (job_push),
    .job_o         (push_job)
  );

  cbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .head_o      (head_job)
  );

  cbs_back #(
    .PolyLength (PolyLength)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (eta_write),
    .eta_i         (eta_q),
    .job_valid_i   (job_valid),
    .job_i         (head_job),
    .job_pop_o     (job_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coefficient_o (coefficient_o),
    .coeff_index_o (coeff_index_o),
    .poly_end_o    (poly_end_o),
    .run_last_o    (run_last_o)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the centered binomial sampler.
`timescale 1ns / 1ps

module tb;
  import cbs_pkg::*;

  localparam int unsigned PolyLen     = PolyLengthDefault;
  localparam int unsigned MaxPerByte  = 4;
  localparam int unsigned DrainCycles = 12;

  localparam logic [ApbAddrW-1:0] EtaAddr   = ApbAddrW'(RegEta) << 2;
  // Address of the register slot after eta; nothing is mapped there.
  localparam logic [ApbAddrW-1:0] NoRegAddr = EtaAddr + ApbAddrW'(4);

  typedef struct {
    logic signed [CoeffW-1:0] coeff;
    logic [IndexW-1:0]        index;
    logic                     poly_end;
    logic                     run_last;
  } coeff_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ApbAddrW-1:0]  paddr         = '0;
  logic [ApbDataW-1:0]  pwdata        = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [ByteW-1:0]     random_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic signed [CoeffW-1:0] coefficient_o;
  logic [IndexW-1:0]    coeff_index_o;
  logic                 poly_end_o;
  logic                 run_last_o;

  centered_binomial_sampler #(.PolyLength(PolyLen)) dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .random_byte_i,
    .out_valid_o, .out_ready_i, .coefficient_o, .coeff_index_o, .poly_end_o, .run_last_o
  );

  always #4 clk_i = ~clk_i;

  // Predicted state of the sampler.
  int unsigned      eta_now      = EtaReset;
  logic [BufW-1:0]  stream_bits  = '0;
  int unsigned      stream_count = 0;
  int unsigned      coeff_pos    = 0;

  logic [ByteW-1:0] byte_queue[$];
  coeff_t           expected_coeffs[$];
  int unsigned      errors = 0;
  bit               calm   = 1'b1;
  int unsigned      gap_left   = 0;
  int unsigned      stall_left = 0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 30);
    end
  endfunction

  function automatic int unsigned eta_effective(logic [EtaW-1:0] code);
    if (code < EtaW'(EtaMin)) begin
      return EtaMin;
    end else if (code > EtaW'(EtaMax)) begin
      return EtaMax;
    end
    return code;
  endfunction

  // Appends one byte to the stream and queues every coefficient it completes.
  function automatic void sample_byte(logic [ByteW-1:0] b);
    logic [31:0] merged;
    int unsigned width;
    int          ones_lo;
    int          ones_hi;
    coeff_t      c;
    coeff_t      batch[$];
    width  = 2 * eta_now;
    merged = 32'(stream_bits) | (32'(b) << stream_count);
    stream_bits  = merged[BufW-1:0];
    stream_count = stream_count + ByteW;
    while (stream_count >= width && batch.size() < MaxPerByte) begin
      ones_lo = 0;
      ones_hi = 0;
      for (int i = 0; i < eta_now; i++) begin
        ones_lo += stream_bits[i];
        ones_hi += stream_bits[i + eta_now];
      end
      c.coeff    = CoeffW'(ones_lo - ones_hi);
      c.index    = IndexW'(coeff_pos);
      c.poly_end = (coeff_pos >= PolyLen - 1);
      c.run_last = 1'b0;
      coeff_pos  = c.poly_end ? 0 : coeff_pos + 1;
      stream_bits  = stream_bits >> width;
      stream_count = stream_count - width;
      batch.push_back(c);
    end
    if (batch.size() > 0) begin
      batch[$].run_last = 1'b1;
    end
    foreach (batch[i]) begin
      expected_coeffs.push_back(batch[i]);
    end
  endfunction

  // Byte driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sample_byte(random_byte_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          in_valid_i    <= 1'b1;
          random_byte_i <= byte_queue.pop_front();
          gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Coefficient monitor and receiver stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    coeff_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_coeffs.size() == 0) begin
          errors++;
          $display("%0t: coefficient %0d index %0d with none expected",
                   $time, coefficient_o, coeff_index_o);
        end else begin
          want = expected_coeffs.pop_front();
          if (coefficient_o !== want.coeff) begin
            errors++;
            $display("%0t: coefficient expected %0d got %0d", $time, want.coeff, coefficient_o);
          end
          if (coeff_index_o !== want.index) begin
            errors++;
            $display("%0t: coeff_index expected %0d got %0d", $time, want.index, coeff_index_o);
          end
          if (poly_end_o !== want.poly_end) begin
            errors++;
            $display("%0t: poly_end expected %0b got %0b", $time, want.poly_end, poly_end_o);
          end
          if (run_last_o !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b got %0b", $time, want.run_last, run_last_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  task automatic apb_write(logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == EtaAddr) begin
      eta_now      = eta_effective(data[EtaW-1:0]);
      stream_bits  = '0;
      stream_count = 0;
      coeff_pos    = 0;
    end
  endtask

  task automatic set_eta(logic [EtaW-1:0] code);
    apb_write(EtaAddr, {(ApbDataW-EtaW)'($urandom()), code});
  endtask

  // Waits until every byte has been taken and every coefficient has come out.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (byte_queue.size() > 0 || in_valid_i || expected_coeffs.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_random(int unsigned count);
    repeat (count) byte_queue.push_back(ByteW'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [EtaW-1:0] phase_eta[6]   = '{3'd1, 3'd4, 3'd3, 3'd5, 3'd6, 3'd2};
    int unsigned     phase_bytes[6] = '{70, 12, 12, 12, 12, 12};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of eta: all-zero, all-one, alternating, nibble and single-bit patterns.
    calm = 1'b1;
    byte_queue = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80};
    wait_idle();

    // A written zero acts as eta 1.
    set_eta(3'd0);
    byte_queue = '{8'hFF, 8'h00, 8'h55, 8'hAA};
    wait_idle();

    // Seven acts as eta 5. The first byte completes nothing, and a write to an
    // unmapped address must leave the held bits alone.
    set_eta(3'd7);
    byte_queue = '{8'h1F};
    wait_idle();
    apb_write(NoRegAddr, $urandom());
    byte_queue = '{8'h80, 8'h0F, 8'hFF};
    wait_idle();

    foreach (phase_eta[p]) begin
      set_eta(phase_eta[p]);
      calm = ($urandom_range(0, 3) == 0);
      push_random(phase_bytes[p]);
      wait_idle();
    end

    calm = 1'b0;
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/cbs_pkg.sv
sv/cbs_front.sv
sv/cbs_fifo.sv
sv/cbs_back.sv
sv/centered_binomial_sampler.sv
verif/tb.sv
